// ===== rtl/zone_temperature_history_tracker_assert.svh =====
// assertion macros for the zone temperature history tracker
// included by modules that carry concurrent checks
`ifndef ZONE_TEMPERATURE_HISTORY_TRACKER_ASSERT_SVH
`define ZONE_TEMPERATURE_HISTORY_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define ZTH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define ZTH_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define ZTH_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define ZTH_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/zth_pkg.sv =====
// types and constants for the zone temperature history tracker
// no dependencies
`timescale 1ns / 1ps
package zth_pkg;
	typedef struct packed {
		logic [3:0]         zone;
		logic signed [15:0] temperature;
		logic               sample_valid;
		logic               calling;
		logic [31:0]        time_ms;
	} zth_in_t;

	typedef struct packed {
		logic               recorded;
		logic [31:0]        sample_count;
		logic [31:0]        calling_count;
		logic signed [15:0] minimum;
		logic signed [15:0] maximum;
		logic signed [15:0] mean;
		logic signed [23:0] rate;
		logic               rate_valid;
		logic [22:0]        heat_gain;
		logic [22:0]        cool_loss;
		logic [15:0]        learning_count;
	} zth_out_t;

	// divider request and reply
	typedef struct packed {
		logic        start;
		logic        neg;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} zth_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} zth_div_rsp_t;

	localparam logic [31:0] MS_PER_HOUR = 32'd3600000;
	localparam logic signed [63:0] RATE_MAX = 64'sd8388607;
	localparam logic signed [63:0] RATE_MIN = -64'sd8388608;
	localparam logic [15:0] UPDATES_MAX = 16'hFFFF;
	localparam logic [1:0] REG_ZONES = 2'd0;
endpackage

// ===== rtl/zth_divider.sv =====
// shared restoring divider, one quotient bit per cycle, truncates toward zero
// depends on zth_pkg
`timescale 1ns / 1ps
module zth_divider (
	input  logic                  clk,
	input  logic                  arst_n,
	input  zth_pkg::zth_div_req_t req,
	output zth_pkg::zth_div_rsp_t rsp
);
	import zth_pkg::*;

	logic [63:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// shift-subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q && (cnt_q == 7'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				den_q  <= req.divisor;
				neg_q  <= req.neg;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[63]};
					quo_q <= {quo_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (~quo_q + 64'd1) : quo_q;
endmodule

// ===== rtl/zone_temperature_history_tracker.sv =====
// zone temperature history tracker top level: store, sequencer, apb port
// depends on zth_pkg, zth_divider and the assertion header
// channel  | direction | handshake      | payload
// in       | input     | valid / ready  | zth_in_t
// out      | output    | valid / ready  | zth_out_t
// cfg      | input     | apb write/read | zones_in_use
// per accepted item: an ignored item goes straight to out, a seed via done,
// a sample whose time did not advance takes the mean division only, one with
// a rate takes rate then mean, and a learn mix adds a learn step in between.
// each division runs 64 steps on the shared divider.
// reset clears all zone state at once (per-zone registers). a stalled result
// holds in the output register and blocks new items until taken.
`timescale 1ns / 1ps
module zone_temperature_history_tracker #(
	parameter int ZONES     = 16,
	parameter int LEARN_CAP = 200
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  zth_pkg::zth_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output zth_pkg::zth_out_t out_data,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import zth_pkg::*;
`include "zone_temperature_history_tracker_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RATE = 3'd1;
	localparam logic [2:0] ST_MEAN = 3'd2;
	localparam logic [2:0] ST_LRN  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;
	localparam logic [15:0] CAP = 16'(LEARN_CAP);

	logic [4:0]  zones_q;
	logic [ZONES-1:0] hist_q, hrate_q;
	logic [31:0] cnt_q [ZONES];
	logic [31:0] ccnt_q [ZONES];
	logic [31:0] last_q [ZONES];
	logic signed [15:0] lo_q [ZONES];
	logic signed [15:0] hi_q [ZONES];
	logic signed [15:0] avg_q [ZONES];
	logic signed [15:0] prev_q [ZONES];
	logic signed [23:0] rate_q [ZONES];
	logic [23:0] gain_q [ZONES];
	logic [23:0] loss_q [ZONES];
	logic [15:0] upd_q [ZONES];

	logic [2:0]  state_q;
	zth_in_t     item_q;
	logic [3:0]  zi;
	logic        lrn_gain_q;
	logic [23:0] lrn_cur_q, lrn_smp_q;
	logic [15:0] lrn_eff_q;
	logic        out_valid_q;
	logic        div_busy_q;
	zth_out_t    out_q;
	zth_div_req_t dreq;
	zth_div_rsp_t drsp;

	zth_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign zi = item_q.zone;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_ZONES[0]) ? {27'd0, zones_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) zones_q <= '0;
		else if (psel && penable && pwrite && paddr[2] == REG_ZONES[0])
			zones_q <= pwdata[4:0];
	end

	// operands for the current step
	logic [31:0] cur_cnt, dt;
	logic signed [16:0] tdiff, adiff;
	logic signed [63:0] prod, qs;
	logic [15:0] eff;
	logic signed [24:0] ldiff;
	assign cur_cnt = cnt_q[zi] + 32'd1;
	assign dt      = item_q.time_ms - last_q[zi];
	assign tdiff   = 17'(item_q.temperature) - 17'(prev_q[zi]);
	assign adiff   = 17'(item_q.temperature) - 17'(avg_q[zi]);
	assign prod    = 64'(tdiff) * 64'(signed'({1'b0, MS_PER_HOUR}));
	assign qs      = signed'(drsp.quotient);
	assign eff     = (upd_q[zi] > CAP) ? CAP : upd_q[zi];
	assign ldiff   = signed'({1'b0, lrn_smp_q}) - signed'({1'b0, lrn_cur_q});

	always_comb begin
		dreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready && in_data.sample_valid
				    && {1'b0, in_data.zone} < zones_q && 9'(in_data.zone) < 9'(ZONES)
				    && hist_q[in_data.zone])
					dreq.start = 1'b0;
			end
			default: dreq = '0;
		endcase
		// starts are issued from registered state below
		if (state_q == ST_RATE && !div_busy_q) begin
			dreq.start    = 1'b1;
			dreq.neg      = prod[63];
			dreq.dividend = prod[63] ? 64'(-prod) : 64'(prod);
			dreq.divisor  = dt;
		end else if (state_q == ST_MEAN && !div_busy_q) begin
			dreq.start    = 1'b1;
			dreq.neg      = adiff[16];
			dreq.dividend = adiff[16] ? 64'(-adiff) : 64'(adiff);
			dreq.divisor  = (cur_cnt == 32'd0) ? 32'd1 : cur_cnt;
		end else if (state_q == ST_LRN && !div_busy_q) begin
			dreq.start    = 1'b1;
			dreq.neg      = ldiff[24];
			dreq.dividend = ldiff[24] ? 64'(-ldiff) : 64'(ldiff);
			dreq.divisor  = 32'(lrn_eff_q) + 32'd1;
		end
	end

	logic signed [63:0] rsat;
	logic signed [23:0] rnext;
	logic [23:0] lsmp;
	assign rsat  = (qs > RATE_MAX) ? RATE_MAX : (qs < RATE_MIN) ? RATE_MIN : qs;
	assign rnext = rsat[23:0];
	assign lsmp  = (rnext == -24'sd8388608) ? 24'd8388607 : 24'(-rnext);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			div_busy_q <= 1'b0;
			out_valid_q <= 1'b0;
			hist_q <= '0;
			hrate_q <= '0;
			for (int i = 0; i < ZONES; i++) begin
				cnt_q[i] <= '0; ccnt_q[i] <= '0; last_q[i] <= '0;
				lo_q[i] <= '0; hi_q[i] <= '0; avg_q[i] <= '0; prev_q[i] <= '0;
				rate_q[i] <= '0; gain_q[i] <= '0; loss_q[i] <= '0; upd_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (dreq.start) div_busy_q <= 1'b1;
			if (drsp.done) div_busy_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						item_q <= in_data;
						if (!in_data.sample_valid || {1'b0, in_data.zone} >= zones_q
						    || 9'(in_data.zone) >= 9'(ZONES)) begin
							out_q <= '0;
							state_q <= ST_OUT;
						end else if (!hist_q[in_data.zone]) begin
							hist_q[in_data.zone] <= 1'b1;
							hrate_q[in_data.zone] <= 1'b0;
							cnt_q[in_data.zone] <= 32'd1;
							ccnt_q[in_data.zone] <= {31'd0, in_data.calling};
							last_q[in_data.zone] <= in_data.time_ms;
							lo_q[in_data.zone] <= in_data.temperature;
							hi_q[in_data.zone] <= in_data.temperature;
							avg_q[in_data.zone] <= in_data.temperature;
							prev_q[in_data.zone] <= in_data.temperature;
							rate_q[in_data.zone] <= '0;
							state_q <= ST_DONE;
						end else begin
							state_q <= (in_data.time_ms > last_q[in_data.zone])
							           ? ST_RATE : ST_MEAN;
						end
					end
				end
				ST_RATE: begin
					if (drsp.done) begin
						rate_q[zi] <= rnext;
						hrate_q[zi] <= 1'b1;
						lrn_eff_q <= eff;
						if (upd_q[zi] != UPDATES_MAX) upd_q[zi] <= upd_q[zi] + 16'd1;
						if (item_q.calling && rnext > 24'sd2) begin
							lrn_gain_q <= 1'b1;
							lrn_cur_q <= gain_q[zi];
							lrn_smp_q <= 24'(rnext);
							if (upd_q[zi] == 16'd0 || gain_q[zi] == 24'd0) begin
								gain_q[zi] <= 24'(rnext);
								state_q <= ST_MEAN;
							end else state_q <= ST_LRN;
						end else if (!item_q.calling && rnext < -24'sd2) begin
							lrn_gain_q <= 1'b0;
							lrn_cur_q <= loss_q[zi];
							lrn_smp_q <= lsmp;
							if (upd_q[zi] == 16'd0 || loss_q[zi] == 24'd0) begin
								loss_q[zi] <= lsmp;
								state_q <= ST_MEAN;
							end else state_q <= ST_LRN;
						end else state_q <= ST_MEAN;
					end
				end
				ST_LRN: begin
					// weight comes from the count before the rate step bumped it
					if (drsp.done) begin
						if (lrn_gain_q) gain_q[zi] <= lrn_cur_q + qs[23:0];
						else loss_q[zi] <= lrn_cur_q + qs[23:0];
						state_q <= ST_MEAN;
					end
				end
				ST_MEAN: begin
					if (drsp.done) begin
						avg_q[zi] <= (cur_cnt == 32'd0) ? item_q.temperature
						             : avg_q[zi] + qs[15:0];
						cnt_q[zi] <= cur_cnt;
						if (item_q.calling) ccnt_q[zi] <= ccnt_q[zi] + 32'd1;
						if (item_q.temperature < lo_q[zi]) lo_q[zi] <= item_q.temperature;
						if (item_q.temperature > hi_q[zi]) hi_q[zi] <= item_q.temperature;
						prev_q[zi] <= item_q.temperature;
						last_q[zi] <= item_q.time_ms;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					out_q.recorded <= 1'b1;
					out_q.sample_count <= cnt_q[zi];
					out_q.calling_count <= ccnt_q[zi];
					out_q.minimum <= lo_q[zi];
					out_q.maximum <= hi_q[zi];
					out_q.mean <= avg_q[zi];
					out_q.rate <= rate_q[zi];
					out_q.rate_valid <= hrate_q[zi];
					out_q.heat_gain <= gain_q[zi][22:0];
					out_q.cool_loss <= loss_q[zi][22:0];
					out_q.learning_count <= upd_q[zi];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`ZTH_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
	`ZTH_ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && in_ready, !in_ready, "double accept")
	`ZTH_ASSERT_IMP(a_div_state, clk, arst_n, drsp.done, state_q == ST_RATE || state_q == ST_MEAN || state_q == ST_LRN, "stray divide")
endmodule

// ===== bench/tb_top.sv =====
// self-checking bench for the zone temperature history tracker
// depends on zth_pkg and the tracker rtl; predicts every item and compares fields
`timescale 1ns / 1ps
module tb_top;
	import zth_pkg::*;

	localparam int NZONE = 16;
	localparam int LEARN_CAP = 200;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 300;

	// one directed stimulus row, with an optional typed-in expectation
	typedef struct {
		zth_in_t  item;
		bit       fixed;
		zth_out_t result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	zth_in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	zth_out_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// tracker model state
	int unsigned zones_bound;
	bit          seeded [NZONE];
	bit          rate_known [NZONE];
	int unsigned n_samples [NZONE];
	int unsigned n_calling [NZONE];
	int unsigned t_last [NZONE];
	int          t_low [NZONE];
	int          t_high [NZONE];
	int          t_avg [NZONE];
	int          t_prev [NZONE];
	int          rate_last [NZONE];
	longint      gain_avg [NZONE];
	longint      loss_avg [NZONE];
	int unsigned n_learn [NZONE];

	zth_out_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	zone_temperature_history_tracker uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #10 clk = ~clk;

	// rolling average with capped weight
	function automatic longint blend_learned(longint cur, longint smp, int unsigned cnt);
		longint w;
		if (cnt == 0 || cur == 0) begin
			return smp;
		end
		w = (cnt > LEARN_CAP) ? LEARN_CAP : cnt;
		return cur + (smp - cur) / (w + 1);
	endfunction

	function automatic void clear_history();
		zones_bound = 0;
		for (int z = 0; z < NZONE; z++) begin
			seeded[z] = 0; rate_known[z] = 0; n_samples[z] = 0; n_calling[z] = 0;
			t_last[z] = 0; t_low[z] = 0; t_high[z] = 0; t_avg[z] = 0; t_prev[z] = 0;
			rate_last[z] = 0; gain_avg[z] = 0; loss_avg[z] = 0; n_learn[z] = 0;
		end
	endfunction

	// predict the result of one sample and advance the zone history
	function automatic zth_out_t track_sample(zth_in_t s);
		zth_out_t r;
		int unsigned z;
		int t;
		longint rt, dt, sp;
		r = '0;
		z = {28'd0, s.zone};
		t = int'(s.temperature);
		if (!s.sample_valid || z >= zones_bound) begin
			return r;
		end
		if (!seeded[z]) begin
			n_samples[z] = 1; n_calling[z] = {31'd0, s.calling};
			t_last[z] = s.time_ms; t_low[z] = t; t_high[z] = t; t_avg[z] = t;
			t_prev[z] = t; rate_last[z] = 0; seeded[z] = 1; rate_known[z] = 0;
		end else begin
			if (s.time_ms > t_last[z]) begin
				dt = longint'(s.time_ms) - longint'(t_last[z]);
				rt = (longint'(t) - t_prev[z]) * 3600000 / dt;
				if (rt > 8388607) rt = 8388607;
				if (rt < -8388608) rt = -8388608;
				rate_last[z] = int'(rt);
				rate_known[z] = 1;
				if (s.calling && rt > 2) begin
					gain_avg[z] = blend_learned(gain_avg[z], rt, n_learn[z]);
				end else if (!s.calling && rt < -2) begin
					sp = -rt;
					if (sp > 8388607) sp = 8388607;
					loss_avg[z] = blend_learned(loss_avg[z], sp, n_learn[z]);
				end
				if (n_learn[z] < 65535) n_learn[z]++;
			end
			n_samples[z]++;
			if (s.calling) n_calling[z]++;
			if (t < t_low[z]) t_low[z] = t;
			if (t > t_high[z]) t_high[z] = t;
			if (n_samples[z] == 0) begin
				t_avg[z] = t;
			end else begin
				t_avg[z] = int'(longint'(t_avg[z]) +
					(longint'(t) - t_avg[z]) / longint'(n_samples[z]));
			end
			t_prev[z] = t;
			t_last[z] = s.time_ms;
		end
		r.recorded = 1'b1;
		r.sample_count = n_samples[z];
		r.calling_count = n_calling[z];
		r.minimum = 16'(t_low[z]);
		r.maximum = 16'(t_high[z]);
		r.mean = 16'(t_avg[z]);
		r.rate = 24'(rate_last[z]);
		r.rate_valid = rate_known[z];
		r.heat_gain = gain_avg[z][22:0];
		r.cool_loss = loss_avg[z][22:0];
		r.learning_count = n_learn[z][15:0];
		return r;
	endfunction

	// random gap, mostly short and a few long
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 40) return 0;
		if (p < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	task automatic write_zones(int unsigned v);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {REG_ZONES[0], 2'b00}; pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		zones_bound = v & 5'h1f;
	endtask

	// offer one item and wait for its acceptance
	task automatic send_sample(zth_in_t s, bit fixed, zth_out_t want);
		zth_out_t p;
		int g;
		g = pick_gap();
		repeat (g + 1) @(negedge clk);
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = track_sample(s);
		if (fixed && p !== want) begin
			$error("directed row: expected %h actual prediction %h", want, p);
			errors++;
		end
		expected_results.push_back(p);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// wait until every expected result has arrived, then let the block settle
	task automatic drain();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic zth_in_t mk(int z, int t, bit v, bit c, int unsigned ms);
		zth_in_t s;
		s.zone = 4'(z); s.temperature = 16'(t); s.sample_valid = v; s.calling = c;
		s.time_ms = ms;
		return s;
	endfunction

	// a random sequence on zones 0 to zmax with a moving clock, plus invalid samples and random times
	task automatic random_phase(int count, int zmax);
		int unsigned now [NZONE];
		zth_in_t s;
		int z, mode;
		zth_out_t none;
		none = '0;
		for (int i = 0; i < NZONE; i++) now[i] = $urandom_range(0, 1000);
		for (int k = 0; k < count; k++) begin
			z = $urandom_range(0, zmax);
			mode = $urandom_range(0, 99);
			s.zone = 4'(z);
			s.sample_valid = (mode >= 5);
			s.calling = 1'($urandom_range(0, 1));
			if (mode < 80) begin
				s.temperature = 16'(t_prev[z] + $signed($urandom_range(0, 200)) - 100);
				now[z] += $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 60000);
				s.time_ms = now[z];
			end else if (mode < 90) begin
				s.temperature = 16'($urandom);
				s.time_ms = $urandom;
			end else begin
				s.temperature = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
				now[z] += $urandom_range(1, 3);
				s.time_ms = now[z];
			end
			send_sample(s, 1'b0, none);
		end
	endtask

	// receiver with random stalls and one long hold-off
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (2000) @(negedge clk);
				hold_off = 1'b0;
			end else begin
				g = pick_gap();
				if (g == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					repeat (g - 1) @(negedge clk);
				end
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		zth_out_t w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation waiting: %h", out_data);
				errors++;
			end else begin
				w = expected_results.pop_front();
				if (out_data.recorded !== w.recorded) begin
					$error("recorded: expected %0d actual %0d", w.recorded, out_data.recorded);
					errors++;
				end
				if (out_data.sample_count !== w.sample_count) begin
					$error("sample_count: expected %0d actual %0d",
						w.sample_count, out_data.sample_count);
					errors++;
				end
				if (out_data.calling_count !== w.calling_count) begin
					$error("calling_count: expected %0d actual %0d",
						w.calling_count, out_data.calling_count);
					errors++;
				end
				if (out_data.minimum !== w.minimum) begin
					$error("minimum: expected %0d actual %0d", w.minimum, out_data.minimum);
					errors++;
				end
				if (out_data.maximum !== w.maximum) begin
					$error("maximum: expected %0d actual %0d", w.maximum, out_data.maximum);
					errors++;
				end
				if (out_data.mean !== w.mean) begin
					$error("mean: expected %0d actual %0d", w.mean, out_data.mean);
					errors++;
				end
				if (out_data.rate !== w.rate) begin
					$error("rate: expected %0d actual %0d", w.rate, out_data.rate);
					errors++;
				end
				if (out_data.rate_valid !== w.rate_valid) begin
					$error("rate_valid: expected %0d actual %0d",
						w.rate_valid, out_data.rate_valid);
					errors++;
				end
				if (out_data.heat_gain !== w.heat_gain) begin
					$error("heat_gain: expected %0d actual %0d", w.heat_gain, out_data.heat_gain);
					errors++;
				end
				if (out_data.cool_loss !== w.cool_loss) begin
					$error("cool_loss: expected %0d actual %0d", w.cool_loss, out_data.cool_loss);
					errors++;
				end
				if (out_data.learning_count !== w.learning_count) begin
					$error("learning_count: expected %0d actual %0d",
						w.learning_count, out_data.learning_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted item or taken result
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n || hold_off) begin
			idle_cycles <= 0;
		end else if (!stim_done || expected_results.size() != 0) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[zone_temperature_history_tracker] ERROR");
				$finish;
			end
		end
	end

	// stimulus sequence
	initial begin
		stim_row_t rows[$];
		stim_row_t row;
		zth_out_t none;
		none = '0;
		clear_history();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no zones bound: everything ignored
		row.fixed = 1; row.result = none;
		row.item = mk(0, 100, 1, 0, 10); rows.push_back(row);
		row.item = mk(15, -5, 1, 1, 10); rows.push_back(row);
		foreach (rows[i]) send_sample(rows[i].item, rows[i].fixed, rows[i].result);
		drain();

		write_zones(16);
		rows.delete();
		row.fixed = 0;
		// seeding at the extremes, invalid sample, frozen time, saturated rates
		row.item = mk(0, 32767, 1, 1, 32'hffff_fff0); rows.push_back(row);
		row.item = mk(0, -32768, 1, 0, 32'hffff_fff1); rows.push_back(row);
		row.item = mk(0, 32767, 1, 1, 32'hffff_fff2); rows.push_back(row);
		row.item = mk(0, 0, 1, 0, 32'hffff_fff2); rows.push_back(row);
		row.item = mk(0, 0, 1, 0, 5); rows.push_back(row);
		row.item = mk(0, 0, 0, 1, 32'hffff_ffff); rows.push_back(row);
		row.item = mk(15, -100, 1, 1, 0); rows.push_back(row);
		row.item = mk(15, 0, 1, 1, 3600000); rows.push_back(row);
		row.item = mk(15, 50, 1, 1, 7200000); rows.push_back(row);
		row.item = mk(15, -10, 1, 0, 10800000); rows.push_back(row);
		row.item = mk(15, -11, 1, 0, 14400000); rows.push_back(row);
		row.item = mk(15, -12, 1, 1, 14400001); rows.push_back(row);
		row.item = mk(7, 1, 1, 0, 100); rows.push_back(row);
		row.item = mk(7, 3, 1, 1, 3600100); rows.push_back(row);
		row.item = mk(7, 6, 1, 1, 7200100); rows.push_back(row);
		foreach (rows[i]) send_sample(rows[i].item, rows[i].fixed, rows[i].result);
		drain();

		// narrow binding: zone 1 and up ignored, zone 0 reseeds nothing
		write_zones(1);
		send_sample(mk(1, 5, 1, 0, 1), 1'b1, none);
		send_sample(mk(0, 5, 1, 0, 32'hffff_ffff), 1'b0, none);
		random_phase(200, 3);
		drain();

		// full binding with a long receiver hold-off in the middle
		write_zones(16);
		random_phase(200, 15);
		hold_off = 1'b1;
		random_phase(300, 4);
		drain();

		write_zones(9);
		random_phase(350, 15);
		drain();
		write_zones(0);
		random_phase(20, 15);
		drain();

		stim_done = 1'b1;
		if (errors == 0) begin
			$display("[zone_temperature_history_tracker] OK");
		end else begin
			$display("[zone_temperature_history_tracker] ERROR");
		end
		$finish;
	end
endmodule
